### sv/lrmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrmp_pkg
// Shared types and constants for the recurrence matrix power unit.
// ----------------------------------------------------------------------------
package lrmp_pkg;
  localparam int MW = 31;
  localparam int NW = 63;
  localparam int PW = 63;
  localparam logic [MW-1:0] MOD_RESET = 31'd1000000007;

  typedef logic [MW-1:0] res_t;
  typedef logic [PW-1:0] acc_t;
endpackage

### sv/lrmp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrmp_mac
// Shared multiply-accumulate-reduce unit: r = (a*b + c*d) mod m.
// Product and sum registered, then reduced by restoring division one bit a
// cycle.
// ----------------------------------------------------------------------------
module lrmp_mac (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  lrmp_pkg::res_t        a,
  input  lrmp_pkg::res_t        b,
  input  lrmp_pkg::res_t        c,
  input  lrmp_pkg::res_t        d,
  input  lrmp_pkg::res_t        m,
  output logic                  done,
  output lrmp_pkg::res_t        r
);
  import lrmp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL0, S_MUL1, S_RED} st_t;
  st_t st;
  logic [61:0] p0;
  acc_t sum;
  logic [MW:0] rem;
  logic [5:0] cnt;
  logic [MW+1:0] trial;

  assign trial = {rem, sum[PW-1]} - {2'b0, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (go) begin
            p0 <= 62'(a) * 62'(b);
            st <= S_MUL0;
          end
        end
        S_MUL0: begin
          sum <= 63'(p0) + 63'(62'(c) * 62'(d));
          rem <= '0;
          cnt <= 6'(PW);
          st <= S_RED;
        end
        S_RED: begin
          if (trial[MW+1]) rem <= {rem[MW-1:0], sum[PW-1]};
          else rem <= trial[MW:0];
          sum <= {sum[PW-2:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            st <= S_MUL1;
          end
        end
        S_MUL1: begin
          r <= rem[MW-1:0];
          done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/linear_recurrence_mod_matrix_power_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_recurrence_mod_matrix_power_unit
// Returns f(index) mod modulus for f = 0,0,1,2, f(n)=3f(n-1)-f(n-2).
// ----------------------------------------------------------------------------
// busy rises the cycle after start is taken and falls when the result strobe
// (valid) fires; the result stays on term_value until the next result, and
// the receiver cannot stall it. Work is square-and-multiply over the bits of
// index-3: each of up to 63 bits takes up to eight matrix-entry products on
// one shared multiply/reduce unit; an index below 4 or a zero modulus is
// answered straight from the setup state.
module linear_recurrence_mod_matrix_power_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_data,
  input  logic        start,
  input  logic [62:0] index,
  output logic        busy,
  output logic        valid,
  output logic [30:0] term_value
);
  import lrmp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_ISSUE, S_WAIT, S_NEXT, S_FIN, S_FWAIT}
    st_t;
  st_t st;
  res_t modulus, m;
  logic [NW-1:0] e;
  res_t a00, a01, a10, a11, b00, b01, b10, b11;
  res_t t0, t1, t2;
  logic [2:0] k;
  logic mac_go, mac_done;
  res_t xa, xb, xc, xd, mr;

  lrmp_mac u_mac (
    .clk(clk), .rst(rst), .go(mac_go), .a(xa), .b(xb), .c(xc), .d(xd),
    .m(m), .done(mac_done), .r(mr)
  );

  // k 0..3: acc*base entries, k 4..7: base*base entries
  always_comb begin
    xa = '0; xb = '0; xc = '0; xd = '0;
    case (k)
      3'd0: begin xa = a00; xb = b00; xc = a01; xd = b10; end
      3'd1: begin xa = a00; xb = b01; xc = a01; xd = b11; end
      3'd2: begin xa = a10; xb = b00; xc = a11; xd = b10; end
      3'd3: begin xa = a10; xb = b01; xc = a11; xd = b11; end
      3'd4: begin xa = b00; xb = b00; xc = b01; xd = b10; end
      3'd5: begin xa = b00; xb = b01; xc = b01; xd = b11; end
      3'd6: begin xa = b10; xb = b00; xc = b11; xd = b10; end
      default: begin xa = b10; xb = b01; xc = b11; xd = b11; end
    endcase
    if ((st == S_FIN) || (st == S_FWAIT)) begin
      xa = 31'd2; xb = a00; xc = 31'd1; xd = a10;
    end
  end

  assign mac_go = (st == S_ISSUE) || (st == S_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      busy <= 1'b0;
      valid <= 1'b0;
      modulus <= MOD_RESET;
    end else begin
      valid <= 1'b0;
      if (cfg_we) modulus <= cfg_data;
      unique case (st)
        S_IDLE: begin
          if (start && !busy) begin
            busy <= 1'b1;
            m <= modulus;
            e <= index;
            st <= S_PREP;
          end
        end
        S_PREP: begin
          if (m == '0) begin
            term_value <= '0; valid <= 1'b1; busy <= 1'b0; st <= S_IDLE;
          end else if (e < 63'd4) begin
            term_value <= (e[1:0] == 2'd3) ? ((m > 31'd2) ? 31'd2 : 31'd0)
                        : (e[1:0] == 2'd2) ? ((m > 31'd1) ? 31'd1 : 31'd0) : 31'd0;
            valid <= 1'b1; busy <= 1'b0; st <= S_IDLE;
          end else begin
            e <= e - 63'd3;
            a00 <= (m == 31'd1) ? 31'd0 : 31'd1; a01 <= '0; a10 <= '0;
            a11 <= (m == 31'd1) ? 31'd0 : 31'd1;
            b00 <= (m == 31'd1) ? 31'd0 : (m == 31'd2) ? 31'd1 : (m == 31'd3) ? 31'd0 : 31'd3;
            b01 <= (m == 31'd1) ? 31'd0 : 31'd1;
            b10 <= m - 31'd1; b11 <= '0;
            st <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (e == '0) st <= S_FIN;
          else begin
            k <= e[0] ? 3'd0 : 3'd4;
            st <= S_ISSUE;
          end
        end
        S_ISSUE: st <= S_WAIT;
        S_WAIT: begin
          if (mac_done) begin
            case (k)
              3'd0, 3'd4: t0 <= mr;
              3'd1, 3'd5: t1 <= mr;
              3'd2, 3'd6: t2 <= mr;
              default: ;
            endcase
            if (k == 3'd3) begin
              a00 <= t0; a01 <= t1; a10 <= t2; a11 <= mr;
            end
            if (k == 3'd7) begin
              b00 <= t0; b01 <= t1; b10 <= t2; b11 <= mr;
              e <= {1'b0, e[NW-1:1]};
              st <= S_NEXT;
            end else begin
              k <= k + 3'd1;
              st <= S_ISSUE;
            end
          end
        end
        S_FIN: st <= S_FWAIT;
        S_FWAIT: begin
          if (mac_done) begin
            term_value <= mr; valid <= 1'b1; busy <= 1'b0; st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
